[hw/rtl/ezvr_pkg.sv]
package ezvr_pkg;

    // One input word: the vector in Q16.16 and three angles in Q4.12 radians.
    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } in_word_t;

    // One result word: the rotated vector in Q16.16, saturated.
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } out_word_t;

    localparam int CORDIC_STAGES = 16;

    // Angle width in Q.30 and CORDIC datapath width.
    localparam int ZW = 35;
    localparam int XW = 34;

    // Total register stages from the input word to the result register.
    localparam int PIPE_DEPTH = CORDIC_STAGES + 9;

    localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 35'sd6746518852;

    localparam logic signed [XW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // Arctangent of 2^-i in Q.30, truncated.
    localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STAGES] = '{
        35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
        35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
        35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
        35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767
    };

endpackage

[hw/rtl/euler_zyx_vector_rotation.sv]
// Euler ZYX vector rotation. Each word carries a Q16.16 vector and roll, pitch
// and yaw angles in Q4.12 radians; the block returns Rz(yaw)*Ry(pitch)*Rx(roll)
// applied to the vector, saturated to Q16.16. A word is taken whenever start
// is high; busy is always low, so one word can enter in every cycle. Each
// result appears on result for one cycle with done high, in input order. The
// pipeline is the 16-stage unrolled CORDIC (one micro-rotation per register
// stage) plus nine stages for angle reduction, rounding, the matrix products
// and the output sums. The receiver cannot hold results off, and none is
// needed: the pipeline never stalls.
module euler_zyx_vector_rotation
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ezvr_pkg::in_word_t   in_word,
    output logic                 done,
    output ezvr_pkg::out_word_t  result
);

    localparam int NS = ezvr_pkg::CORDIC_STAGES;
    localparam int ZW = ezvr_pkg::ZW;
    localparam int XW = ezvr_pkg::XW;
    localparam int PD = ezvr_pkg::PIPE_DEPTH;

    // Stage numbers of the later steps.
    localparam int ST_ROUND = NS + 3;
    localparam int ST_M1    = NS + 4;
    localparam int ST_M2    = NS + 5;
    localparam int ST_M3    = NS + 6;
    localparam int ST_MUL   = NS + 7;
    localparam int ST_SUM   = NS + 8;

    // Valid bits travel with the data, one per stage.
    logic [PD:1] vld_reg;
    logic [PD:1] vld_next;

    // The vector rides alongside until the final multiplies.
    logic signed [31:0] vec_reg [1:ST_M3][3];

    logic signed [15:0] ang_in [3];

    logic signed [ZW-1:0] red_reg [3];
    logic signed [ZW-1:0] z_reg   [0:NS][3];
    logic signed [XW-1:0] x_reg   [0:NS][3];
    logic signed [XW-1:0] y_reg   [0:NS][3];
    logic                 flip_reg [0:NS][3];

    logic signed [15:0] cos_reg [3];
    logic signed [15:0] sin_reg [3];

    // First matrix stage: products of two Q1.15 values.
    logic signed [31:0] p_sxsy_reg, p_cxsy_reg, p_cxsz_reg, p_sxsz_reg, p_cxcz_reg;
    logic signed [31:0] p_sxcz_reg, p_cycz_reg, p_cysz_reg, p_sxcy_reg, p_cxcy_reg;
    logic signed [15:0] sy_m1_reg, cz_m1_reg, sz_m1_reg;

    // Second matrix stage: triple products in Q.45 and pass-through terms.
    logic signed [47:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [31:0] q01_reg, q02_reg, q11_reg, q12_reg;
    logic signed [XW-1:0] m00_m2_reg, m10_m2_reg, m20_m2_reg, m21_m2_reg, m22_m2_reg;

    logic signed [XW-1:0] m_reg   [3][3];
    logic signed [65:0]   prod_reg [3][3];
    logic signed [67:0]   acc_reg  [3];
    ezvr_pkg::out_word_t  result_reg;

    assign busy = 1'b0;

    assign ang_in[0] = in_word.roll_angle;
    assign ang_in[1] = in_word.pitch_angle;
    assign ang_in[2] = in_word.yaw_angle;

    // Rounds a Q.45 value half up to Q.30.
    function automatic logic signed [XW-1:0] round_q45(input logic signed [48:0] v);
        logic signed [48:0] r;
        r = (v + 49'sd16384) >>> 15;
        return r[XW-1:0];
    endfunction

    // Valid chain.
    always_comb
    begin
        vld_next = {vld_reg[PD-1:1], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Vector delay line.
    always_ff @(posedge clk)
    begin
        vec_reg[1][0] <= in_word.vec_x;
        vec_reg[1][1] <= in_word.vec_y;
        vec_reg[1][2] <= in_word.vec_z;
        for (int s = 2; s <= ST_M3; s++)
        begin
            vec_reg[s] <= vec_reg[s-1];
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_angle
        logic signed [ZW-1:0] z_ext;
        logic signed [ZW-1:0] red_next;
        logic signed [ZW-1:0] fold_next;
        logic                 fold_flip;
        logic signed [ZW-1:0] xf;
        logic signed [ZW-1:0] yf;
        logic signed [ZW-1:0] xr;
        logic signed [ZW-1:0] yr;
        logic signed [15:0]   c_next;
        logic signed [15:0]   s_next;

        // Widen to Q.30 and wrap by one full turn into [-PI, PI].
        always_comb
        begin
            z_ext = $signed({ang_in[a][15], ang_in[a], 18'd0});
            if (z_ext > ezvr_pkg::Q30_PI)
            begin
                red_next = z_ext - ezvr_pkg::Q30_TWO_PI;
            end
            else if (z_ext < -ezvr_pkg::Q30_PI)
            begin
                red_next = z_ext + ezvr_pkg::Q30_TWO_PI;
            end
            else
            begin
                red_next = z_ext;
            end
        end

        // Fold into [-PI/2, PI/2]; a fold negates sine and cosine.
        always_comb
        begin
            fold_flip = 1'b0;
            fold_next = red_reg[a];
            if (red_reg[a] > ezvr_pkg::Q30_HALF_PI)
            begin
                fold_next = red_reg[a] - ezvr_pkg::Q30_PI;
                fold_flip = 1'b1;
            end
            else if (red_reg[a] < -ezvr_pkg::Q30_HALF_PI)
            begin
                fold_next = red_reg[a] + ezvr_pkg::Q30_PI;
                fold_flip = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            red_reg[a]     <= red_next;
            z_reg[0][a]    <= fold_next;
            x_reg[0][a]    <= ezvr_pkg::CORDIC_GAIN_INV;
            y_reg[0][a]    <= '0;
            flip_reg[0][a] <= fold_flip;
        end

        // One CORDIC micro-rotation per stage.
        for (genvar k = 0; k < NS; k++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                flip_reg[k+1][a] <= flip_reg[k][a];
                if (z_reg[k][a] >= 0)
                begin
                    x_reg[k+1][a] <= x_reg[k][a] - (y_reg[k][a] >>> k);
                    y_reg[k+1][a] <= y_reg[k][a] + (x_reg[k][a] >>> k);
                    z_reg[k+1][a] <= z_reg[k][a] - ezvr_pkg::ATAN_Q30[k];
                end
                else
                begin
                    x_reg[k+1][a] <= x_reg[k][a] + (y_reg[k][a] >>> k);
                    y_reg[k+1][a] <= y_reg[k][a] - (x_reg[k][a] >>> k);
                    z_reg[k+1][a] <= z_reg[k][a] + ezvr_pkg::ATAN_Q30[k];
                end
            end
        end

        // Undo the fold, round half up to Q1.15 and saturate.
        always_comb
        begin
            xf = flip_reg[NS][a] ? -ZW'(x_reg[NS][a]) : ZW'(x_reg[NS][a]);
            yf = flip_reg[NS][a] ? -ZW'(y_reg[NS][a]) : ZW'(y_reg[NS][a]);
            xr = (xf + 35'sd16384) >>> 15;
            yr = (yf + 35'sd16384) >>> 15;
            if (xr > 35'sd32767)
            begin
                c_next = 16'sh7fff;
            end
            else if (xr < -35'sd32768)
            begin
                c_next = -16'sh8000;
            end
            else
            begin
                c_next = xr[15:0];
            end
            if (yr > 35'sd32767)
            begin
                s_next = 16'sh7fff;
            end
            else if (yr < -35'sd32768)
            begin
                s_next = -16'sh8000;
            end
            else
            begin
                s_next = yr[15:0];
            end
        end

        always_ff @(posedge clk)
        begin
            cos_reg[a] <= c_next;
            sin_reg[a] <= s_next;
        end
    end

    // Products of two sines or cosines.
    always_ff @(posedge clk)
    begin
        p_sxsy_reg <= sin_reg[0] * sin_reg[1];
        p_cxsy_reg <= cos_reg[0] * sin_reg[1];
        p_cxsz_reg <= cos_reg[0] * sin_reg[2];
        p_sxsz_reg <= sin_reg[0] * sin_reg[2];
        p_cxcz_reg <= cos_reg[0] * cos_reg[2];
        p_sxcz_reg <= sin_reg[0] * cos_reg[2];
        p_cycz_reg <= cos_reg[1] * cos_reg[2];
        p_cysz_reg <= cos_reg[1] * sin_reg[2];
        p_sxcy_reg <= sin_reg[0] * cos_reg[1];
        p_cxcy_reg <= cos_reg[0] * cos_reg[1];
        sy_m1_reg  <= sin_reg[1];
        cz_m1_reg  <= cos_reg[2];
        sz_m1_reg  <= sin_reg[2];
    end

    // Triple products and the exact matrix elements.
    always_ff @(posedge clk)
    begin
        t01_reg    <= p_sxsy_reg * cz_m1_reg;
        t02_reg    <= p_cxsy_reg * cz_m1_reg;
        t11_reg    <= p_sxsy_reg * sz_m1_reg;
        t12_reg    <= p_cxsy_reg * sz_m1_reg;
        q01_reg    <= p_cxsz_reg;
        q02_reg    <= p_sxsz_reg;
        q11_reg    <= p_cxcz_reg;
        q12_reg    <= p_sxcz_reg;
        m00_m2_reg <= XW'(p_cycz_reg);
        m10_m2_reg <= XW'(p_cysz_reg);
        m20_m2_reg <= -($signed({sy_m1_reg[15], sy_m1_reg, 17'd0}) >>> 2);
        m21_m2_reg <= XW'(p_sxcy_reg);
        m22_m2_reg <= XW'(p_cxcy_reg);
    end

    // Combine into Q2.30 matrix elements.
    always_ff @(posedge clk)
    begin
        m_reg[0][0] <= m00_m2_reg;
        m_reg[0][1] <= round_q45(49'(t01_reg) - $signed({q01_reg[31], q01_reg[31], q01_reg, 15'd0}));
        m_reg[0][2] <= round_q45(49'(t02_reg) + $signed({q02_reg[31], q02_reg[31], q02_reg, 15'd0}));
        m_reg[1][0] <= m10_m2_reg;
        m_reg[1][1] <= round_q45(49'(t11_reg) + $signed({q11_reg[31], q11_reg[31], q11_reg, 15'd0}));
        m_reg[1][2] <= round_q45(49'(t12_reg) - $signed({q12_reg[31], q12_reg[31], q12_reg, 15'd0}));
        m_reg[2][0] <= m20_m2_reg;
        m_reg[2][1] <= m21_m2_reg;
        m_reg[2][2] <= m22_m2_reg;
    end

    // Nine vector-by-element products.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= vec_reg[ST_M3][c] * m_reg[r][c];
            end
        end
    end

    // Row sums of the products, each scaled down by four first.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_reg[r] <= 68'(prod_reg[r][0] >>> 2) + 68'(prod_reg[r][1] >>> 2)
                        + 68'(prod_reg[r][2] >>> 2);
        end
    end

    // Round to Q16.16 and saturate.
    logic signed [67:0] rnd [3];
    logic signed [31:0] sat_val [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = (acc_reg[r] + 68'sd134217728) >>> 28;
            if (rnd[r] > 68'sd2147483647)
            begin
                sat_val[r] = 32'sh7fffffff;
            end
            else if (rnd[r] < -68'sd2147483648)
            begin
                sat_val[r] = 32'sh80000000;
            end
            else
            begin
                sat_val[r] = rnd[r][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_x <= sat_val[0];
        result_reg.out_y <= sat_val[1];
        result_reg.out_z <= sat_val[2];
    end

    assign done   = vld_reg[PD];
    assign result = result_reg;

    // Stage bookkeeping: the sum stage feeds the result register.
    if (ST_SUM + 1 != PD || ST_ROUND + 1 != ST_M1 || ST_M2 + 1 != ST_M3
        || ST_MUL + 1 != ST_SUM)
    begin : g_bad_depth
        $error("Pipeline depth does not match the stage plan.");
    end

endmodule

[test/euler_zyx_vector_rotation_tb.sv]
module euler_zyx_vector_rotation_tb;

    import ezvr_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 10;
    localparam int RANDOM_WORDS = 530;

    // Predicts rotated vectors and checks them against the results in order.
    class rotation_scoreboard;
        out_word_t pending[$];
        int errors = 0;

        // Cosine and sine of a Q4.12 angle in Q1.15, by a 16-stage CORDIC.
        static function void trig(input logic signed [15:0] ang,
                                  output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit flip;
            x = CORDIC_GAIN_INV;
            y = 0;
            z = longint'(ang) * 262144;
            flip = 0;
            while (z > Q30_PI) z -= Q30_TWO_PI;
            while (z < -longint'(Q30_PI)) z += Q30_TWO_PI;
            if (z > Q30_HALF_PI)
            begin
                z -= Q30_PI;
                flip = 1;
            end
            else if (z < -longint'(Q30_HALF_PI))
            begin
                z += Q30_PI;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= ATAN_Q30[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += ATAN_Q30[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = sat((x + 16384) >>> 15, -32768, 32767);
            s = sat((y + 16384) >>> 15, -32768, 32767);
        endfunction

        static function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // One output component: dot product of the vector with a matrix row.
        static function logic signed [31:0] dot(longint vx, longint vy, longint vz,
                                                longint m0, longint m1, longint m2);
            longint acc;
            acc = ((vx * m0) >>> 2) + ((vy * m1) >>> 2) + ((vz * m2) >>> 2);
            return 32'(sat((acc + 134217728) >>> 28, -64'sd2147483648,
                           64'sd2147483647));
        endfunction

        // Notes an accepted input word and queues its rotated vector.
        function void note(in_word_t w);
            longint cx, sx, cy, sy, cz, sz, vx, vy, vz;
            longint m01, m02, m11, m12;
            out_word_t r;
            vx = w.vec_x;
            vy = w.vec_y;
            vz = w.vec_z;
            trig(w.roll_angle, cx, sx);
            trig(w.pitch_angle, cy, sy);
            trig(w.yaw_angle, cz, sz);
            m01 = (sx * sy * cz - cx * sz * 32768 + 16384) >>> 15;
            m02 = (cx * sy * cz + sx * sz * 32768 + 16384) >>> 15;
            m11 = (sx * sy * sz + cx * cz * 32768 + 16384) >>> 15;
            m12 = (cx * sy * sz - sx * cz * 32768 + 16384) >>> 15;
            r.out_x = dot(vx, vy, vz, cy * cz, m01, m02);
            r.out_y = dot(vx, vy, vz, cy * sz, m11, m12);
            r.out_z = dot(vx, vy, vz, -sy * 32768, sx * cy, cx * cy);
            pending.push_back(r);
        endfunction

        // Checks one result word against the oldest prediction.
        function void check(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: result %h with no word outstanding", $realtime, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.out_x !== exp_w.out_x)
            begin
                $display("%0t: out_x expected %0d actual %0d", $realtime,
                         exp_w.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_w.out_y)
            begin
                $display("%0t: out_y expected %0d actual %0d", $realtime,
                         exp_w.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== exp_w.out_z)
            begin
                $display("%0t: out_z expected %0d actual %0d", $realtime,
                         exp_w.out_z, got.out_z);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  in_word;
    logic      done;
    out_word_t result;

    rotation_scoreboard sb;
    int idle_cycles;
    bit no_gaps;

    euler_zyx_vector_rotation uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_word (in_word),
        .done    (done),
        .result  (result)
    );

    // Clock with a 12-unit period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Monitor: accepted words, results and the stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note(in_word);
            end
            if (done)
            begin
                sb.check(result);
            end
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Presents one word and holds it until it is taken, then sometimes idles a while.
    task automatic send_word(in_word_t w);
        int r, gap;
        start <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic signed [15:0] ro,
                               logic signed [15:0] pi, logic signed [15:0] ya);
        in_word_t w;
        w.vec_x = x;
        w.vec_y = y;
        w.vec_z = z;
        w.roll_angle = ro;
        w.pitch_angle = pi;
        w.yaw_angle = ya;
        send_word(w);
    endtask

    function automatic logic signed [31:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
        if (r == 8) return 32'h7FFFFFFF;
        return 32'h80000000;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom);
        if (r == 7) return 16'sd6434 + 16'($signed($urandom_range(0, 4)) - 2);
        if (r == 8) return 16'sd12868 + 16'($signed($urandom_range(0, 4)) - 2);
        return -16'sd12868 + 16'($signed($urandom_range(0, 4)) - 2);
    endfunction

    // Waits until every outstanding result has come back. The first edge
    // lets the monitor note the word taken at the edge just passed.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        idle_cycles = 0;
        no_gaps = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: identity, field extremes, quarter and half turns,
        // wrapping angles and saturating outputs.
        send_fields(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);
        send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0);
        send_fields(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
        send_fields(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h7FFF, 16'h8000,
                    16'h7FFF);
        send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 16'sd3217);
        send_fields(32'h80000000, 32'h80000000, 32'h80000000, 16'sd3217, 16'sd3217,
                    16'sd3217);
        send_fields(32'sh00010000, 0, 0, 16'sd6434, 0, 0);
        send_fields(0, 32'sh00010000, 0, 0, 16'sd6434, 0);
        send_fields(0, 0, 32'sh00010000, 0, 0, 16'sd6434);
        send_fields(32'sh00010000, 32'sh00010000, 32'sh00010000, -16'sd6434,
                    -16'sd6434, -16'sd6434);
        send_fields(32'sh00050000, -32'sh00030000, 32'sh00001000, 16'sd12868,
                    -16'sd12868, 16'sd12868);
        send_fields(32'sh00050000, 32'sh00030000, -32'sh00001000, 16'sd12869,
                    16'sd12867, -16'sd12869);
        send_fields(32'sh12345678, -32'sh0ABCDEF0, 32'sh01000000, 16'h8000, 16'h8000,
                    16'h8000);
        send_fields(32'sh12345678, -32'sh0ABCDEF0, 32'sh01000000, 16'h7FFF, 16'h7FFF,
                    16'h7FFF);
        send_fields(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 16'h5555, 16'hAAAA,
                    16'h00FF);
        send_fields(32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0, 16'hAAAA, 16'h5555,
                    16'hFF00);
        send_fields(1, -1, 1, 16'sd25736, -16'sd25736, 16'sd19302);

        // Hold off until the pipeline is empty once.
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            no_gaps = (n >= 150 && n < 250);
            if (n == 350) drain();
            send_fields(rand_comp(), rand_comp(), rand_comp(), rand_angle(),
                        rand_angle(), rand_angle());
        end
        no_gaps = 0;

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
